[src/mct_pkg.sv]
// Shared constants, opcodes and types of the migration chunk tracker.
package mct_pkg;

  // Chunk count and derived widths
  localparam int NUM_CHUNKS = 256;
  localparam int CHUNK_W    = $clog2(NUM_CHUNKS);
  localparam int IDX_W      = 8;
  localparam int OP_W       = 3;

  // The lowest-untouched search splits the bitmap into groups
  localparam int GRP_SIZE = 16;
  localparam int NUM_GRPS = NUM_CHUNKS / GRP_SIZE;
  localparam int GRP_W    = $clog2(NUM_GRPS);
  localparam int BIT_W    = $clog2(GRP_SIZE);

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR   = 3'd0,
    OP_TOUCH   = 3'd1,
    OP_UNTOUCH = 3'd2,
    OP_POP     = 3'd3,
    OP_QUERY   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    CS_ABSENT    = 2'd0,
    CS_UNTOUCHED = 2'd1,
    CS_TOUCHED   = 2'd2
  } chunk_state_e;

  // Bitmap update issued once per executed command
  typedef struct packed {
    logic               en;
    op_e                op;
    logic [CHUNK_W-1:0] idx;
    logic               idx_ok;
    logic               pop_hit;
    logic [CHUNK_W-1:0] pop_idx;
  } upd_t;

endpackage

[src/mct_if.sv]
// Command and response channel interfaces of the migration chunk tracker.
interface mct_cmd_if import mct_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [IDX_W-1:0] chunk_index;

  modport source (output valid, output opcode, output chunk_index, input ready);
  modport sink   (input valid, input opcode, input chunk_index, output ready);
endinterface

interface mct_rsp_if import mct_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             found;
  logic [IDX_W-1:0] result_index;
  logic [1:0]       chunk_state;

  modport source (output valid, output found, output result_index, output chunk_state,
                  input ready);
  modport sink   (input valid, input found, input result_index, input chunk_state,
                  output ready);
endinterface

[src/migration_chunk_tracker.sv]
// Migration chunk tracker: one command in, one response out, per transfer.
// Each command transfer gets exactly one response transfer, in order. The
// block takes one command per cycle unless a held response stalls it. A
// command is held in the command register after its transfer and is loaded
// into the response register once that register is empty or its response is
// taken. Both stages hold under back-pressure. Chunk states live in two flop
// bitmaps that reset clears at once, so no clearing pass is needed after
// reset. The pop search reads a registered per-group summary of the untouched
// bitmap, so finding the lowest untouched chunk is a combinational group pick
// followed by a pick inside that group.
module migration_chunk_tracker import mct_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  mct_cmd_if.sink       cmd_i,
  mct_rsp_if.source     rsp_o
);

  // Command register
  logic             a_valid_q;
  logic [OP_W-1:0]  a_op_q;
  logic [IDX_W-1:0] a_idx_q;
  logic             a_fire;

  // Response register
  logic             r_valid_q;
  logic             r_found_q, r_found_d;
  logic [IDX_W-1:0] r_idx_q, r_idx_d;
  logic [1:0]       r_state_q, r_state_d;

  // Bitmap view and search result
  logic [NUM_CHUNKS-1:0] untouched;
  logic [NUM_CHUNKS-1:0] touched;
  logic [NUM_GRPS-1:0]   group_any;
  logic                  pop_hit;
  logic [CHUNK_W-1:0]    pop_idx;

  op_e                op;
  logic               idx_ok;
  logic [CHUNK_W-1:0] cidx;
  chunk_state_e       cur_state;
  upd_t               upd;

  // Handshakes
  assign a_fire      = a_valid_q && (!r_valid_q || rsp_o.ready);
  assign cmd_i.ready = !a_valid_q || a_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (cmd_i.ready) begin
      a_valid_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ready && cmd_i.valid) begin
      a_op_q  <= cmd_i.opcode;
      a_idx_q <= cmd_i.chunk_index;
    end
  end

  // Decode and current state of the named chunk
  assign op     = op_e'(a_op_q);
  assign idx_ok = int'(a_idx_q) < NUM_CHUNKS;
  assign cidx   = a_idx_q[CHUNK_W-1:0];

  always_comb begin
    cur_state = CS_ABSENT;
    if (idx_ok) begin
      if (touched[cidx])        cur_state = CS_TOUCHED;
      else if (untouched[cidx]) cur_state = CS_UNTOUCHED;
    end
  end

  mct_first_finder u_finder (
    .untouched_i (untouched),
    .group_any_i (group_any),
    .hit_o       (pop_hit),
    .idx_o       (pop_idx)
  );

  always_comb begin
    upd.en      = a_fire;
    upd.op      = op;
    upd.idx     = cidx;
    upd.idx_ok  = idx_ok;
    upd.pop_hit = pop_hit;
    upd.pop_idx = pop_idx;
  end

  mct_bitmap u_bitmap (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .upd_i       (upd),
    .untouched_o (untouched),
    .touched_o   (touched),
    .group_any_o (group_any)
  );

  // Response fields
  always_comb begin
    if (op == OP_POP) begin
      r_found_d = pop_hit;
      r_idx_d   = pop_hit ? IDX_W'(pop_idx) : '0;
      r_state_d = pop_hit ? CS_UNTOUCHED : CS_ABSENT;
    end else begin
      r_found_d = 1'b1;
      r_idx_d   = a_idx_q;
      r_state_d = cur_state;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
    end else if (a_fire) begin
      r_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      r_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_fire) begin
      r_found_q <= r_found_d;
      r_idx_q   <= r_idx_d;
      r_state_q <= r_state_d;
    end
  end

  assign rsp_o.valid        = r_valid_q;
  assign rsp_o.found        = r_found_q;
  assign rsp_o.result_index = r_idx_q;
  assign rsp_o.chunk_state  = r_state_q;

  // A chunk is never untouched and touched at once
  assert property (@(posedge clk_i) disable iff (!rst_ni) (untouched & touched) == '0)
    else $error("chunk both untouched and touched");

  // A popped chunk leaves the untouched set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_fire && op == OP_POP && pop_hit |=> !untouched[$past(pop_idx)])
    else $error("popped chunk still untouched");

  // The search hit always lands on an untouched chunk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_hit |-> untouched[pop_idx])
    else $error("search returned a chunk that is not untouched");

endmodule

[src/mct_bitmap.sv]
// Untouched and touched bitmaps in flops, with a registered per-group summary.
module mct_bitmap import mct_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  upd_t                 upd_i,
  output logic [NUM_CHUNKS-1:0] untouched_o,
  output logic [NUM_CHUNKS-1:0] touched_o,
  output logic [NUM_GRPS-1:0]   group_any_o
);

  logic [NUM_CHUNKS-1:0] untouched_q, untouched_d;
  logic [NUM_CHUNKS-1:0] touched_q, touched_d;
  logic [NUM_GRPS-1:0]   group_any_q, group_any_d;
  logic [NUM_GRPS-1:0]   group_or;

  // Next bitmap contents
  always_comb begin
    untouched_d = untouched_q;
    touched_d   = touched_q;
    if (upd_i.en) begin
      case (upd_i.op)
        OP_CLEAR: begin
          untouched_d = '0;
          touched_d   = '0;
        end
        OP_TOUCH: begin
          if (upd_i.idx_ok) begin
            if (untouched_q[upd_i.idx]) begin
              untouched_d[upd_i.idx] = 1'b0;
              touched_d[upd_i.idx]   = 1'b1;
            end else if (!touched_q[upd_i.idx]) begin
              untouched_d[upd_i.idx] = 1'b1;
            end
          end
        end
        OP_UNTOUCH: begin
          if (upd_i.idx_ok) begin
            untouched_d[upd_i.idx] = 1'b0;
            touched_d[upd_i.idx]   = 1'b0;
          end
        end
        OP_POP: begin
          if (upd_i.pop_hit) begin
            untouched_d[upd_i.pop_idx] = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Group summary follows the next bitmap so it is ready with it
  always_comb begin
    for (int g = 0; g < NUM_GRPS; g++) begin
      group_any_d[g] = |untouched_d[g*GRP_SIZE +: GRP_SIZE];
      group_or[g]    = |untouched_q[g*GRP_SIZE +: GRP_SIZE];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      untouched_q <= '0;
      touched_q   <= '0;
      group_any_q <= '0;
    end else begin
      untouched_q <= untouched_d;
      touched_q   <= touched_d;
      group_any_q <= group_any_d;
    end
  end

  assign untouched_o = untouched_q;
  assign touched_o   = touched_q;
  assign group_any_o = group_any_q;

  // Summary must always match the bitmap it covers
  assert property (@(posedge clk_i) disable iff (!rst_ni) group_any_q == group_or)
    else $error("group summary out of step with untouched bitmap");

  // A clear empties both bitmaps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i.en && upd_i.op == OP_CLEAR |=> untouched_q == '0 && touched_q == '0)
    else $error("clear left chunks present");

endmodule

[src/mct_first_finder.sv]
// Lowest untouched chunk: pick the first busy group, then the first bit in it.
module mct_first_finder import mct_pkg::*; (
  input  logic [NUM_CHUNKS-1:0] untouched_i,
  input  logic [NUM_GRPS-1:0]   group_any_i,
  output logic                  hit_o,
  output logic [CHUNK_W-1:0]    idx_o
);

  logic [GRP_W-1:0]    grp_sel;
  logic [GRP_SIZE-1:0] grp_word;
  logic [BIT_W-1:0]    bit_sel;

  // First group with any untouched chunk
  always_comb begin
    grp_sel = '0;
    for (int g = NUM_GRPS - 1; g >= 0; g--) begin
      if (group_any_i[g]) grp_sel = GRP_W'(g);
    end
  end

  assign grp_word = untouched_i[{grp_sel, {BIT_W{1'b0}}} +: GRP_SIZE];

  // First set bit inside that group
  always_comb begin
    bit_sel = '0;
    for (int b = GRP_SIZE - 1; b >= 0; b--) begin
      if (grp_word[b]) bit_sel = BIT_W'(b);
    end
  end

  assign hit_o = |group_any_i;
  assign idx_o = {grp_sel, bit_sel};

endmodule
